@@ rtl/sorted_set_insert_macros.svh @@
// assertion macros for the sorted set insertion block
// used by the checker module; no other dependencies
`ifndef SORTED_SET_INSERT_MACROS_SVH
`define SORTED_SET_INSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define SSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ssi_pkg.sv @@
// shared constants and types for the sorted set insertion block
// no dependencies
package ssi_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [STATUS_W-1:0]    status_t;

  // result status codes
  localparam status_t STATUS_INSERTED = 2'd0;
  localparam status_t STATUS_PRESENT  = 2'd1;
  localparam status_t STATUS_FULL     = 2'd2;

endpackage

@@ rtl/ssi_if.sv @@
// valid/ready channel interfaces for input values and results
// depends on ssi_pkg
interface ssi_in_if import ssi_pkg::*;;
  logic   valid;
  logic   ready;
  value_t new_value;

  modport source (output valid, output new_value, input ready);
  modport sink (input valid, input new_value, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*;;
  logic    valid;
  logic    ready;
  count_t  entry_count;
  count_t  position;
  status_t status;

  modport source (output valid, output entry_count, output position, output status,
                  input ready);
  modport sink (input valid, input entry_count, input position, input status,
                output ready);
endinterface

@@ rtl/sorted_set_insert.sv @@
// Sorted set insertion: keeps up to CAPACITY (64) signed values in ascending order
// without duplicates in a store with one write and one read port, and for each value
// returns the new count, its position and a status (inserted, already present, store
// full). One value is processed at a time through one compare unit and the one store.
// The search compares entries from the bottom up to the insertion point, entries from
// there on move up one slot, top first, and the value is written; a value above every
// entry needs no moves. The sequencer returns to idle before the next value is taken,
// and a result held back by the sink stalls it in its last state. Each search or move
// step has a read state and a compare or write-back state, as the store's read data is
// registered first. A new value is taken while the previous result still waits in the
// output register. Reset empties the set at once; no clearing pass is needed.
module sorted_set_insert import ssi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssi_in_if.sink    in_i,
  ssi_out_if.source out_o
);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SRCH_RD = 3'd1;
  localparam logic [2:0] ST_SRCH_CM = 3'd2;
  localparam logic [2:0] ST_MOVE_RD = 3'd3;
  localparam logic [2:0] ST_MOVE_WR = 3'd4;
  localparam logic [2:0] ST_PUT     = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  value_t           key_q, key_d;
  status_t          stat_q, stat_d;

  logic             out_valid_q;
  count_t           out_count_q;
  count_t           out_pos_q;
  status_t          out_stat_q;

  // value store, one write and one registered read a cycle
  value_t           mem_q [CAPACITY];
  value_t           rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  value_t           wr_data;

  logic             in_xfer;
  logic             out_load;
  logic             is_equal;
  logic             is_less;
  logic             full;
  logic [CNT_W-1:0] idx_m1;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);
  assign full     = (cnt_q == CNT_W'(CAPACITY));
  assign idx_m1   = idx_q - 1'b1;

  // shared compare unit: key against the entry just read
  assign is_equal = (key_q == rd_data_q);
  assign is_less  = ($signed(key_q) < $signed(rd_data_q));

  // store port selection
  always_comb begin
    rd_addr = idx_q[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[ADDR_W-1:0];
    wr_data = rd_data_q;
    case (state_q)
      ST_MOVE_RD: begin
        rd_addr = idx_m1[ADDR_W-1:0];
      end
      ST_MOVE_WR: begin
        wr_en = 1'b1;
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[ADDR_W-1:0];
        wr_data = key_q;
      end
      default: begin
        rd_addr = idx_q[ADDR_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    key_d   = key_q;
    stat_d  = stat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          key_d   = in_i.new_value;
          idx_d   = '0;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (idx_q == cnt_q) begin
          // value above every stored entry
          pos_d = idx_q;
          if (full) begin
            stat_d  = STATUS_FULL;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_PUT;
          end
        end else begin
          state_d = ST_SRCH_CM;
        end
      end
      ST_SRCH_CM: begin
        if (is_equal) begin
          pos_d   = idx_q;
          stat_d  = STATUS_PRESENT;
          state_d = ST_FINISH;
        end else if (is_less) begin
          pos_d = idx_q;
          if (full) begin
            stat_d  = STATUS_FULL;
            state_d = ST_FINISH;
          end else begin
            idx_d   = cnt_q;
            state_d = ST_MOVE_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_MOVE_RD: begin
        if (idx_q == pos_q) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_MOVE_WR;
        end
      end
      ST_MOVE_WR: begin
        idx_d   = idx_m1;
        state_d = ST_MOVE_RD;
      end
      ST_PUT: begin
        cnt_d   = cnt_q + 1'b1;
        stat_d  = STATUS_INSERTED;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    stat_q <= stat_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= COUNT_W'(cnt_q);
      out_pos_q   <= COUNT_W'(pos_q);
      out_stat_q  <= stat_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.position    = out_pos_q;
  assign out_o.status      = out_stat_q;

endmodule

@@ rtl/ssi_chk.sv @@
// port-level checker for the sorted set insertion block, bound into the block's module
// depends on ssi_pkg and sorted_set_insert_macros.svh
`include "sorted_set_insert_macros.svh"

module ssi_chk import ssi_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input count_t  entry_count_i,
  input count_t  position_i,
  input status_t status_i
);

  // a result held back by the sink stays offered
  `SSI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // the block is busy right after taking a value
  `SSI_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken twice in a row")

  // position never beyond the count, count never beyond the capacity
  `SSI_ASSERT_NOW(a_pos_range, clk_i, rst_ni, out_valid_i, (position_i <= entry_count_i) && (entry_count_i <= count_t'(CAPACITY)), "position or count out of range")

  // only defined status codes, and a full store reports full count
  `SSI_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_i, (status_i == STATUS_INSERTED) || (status_i == STATUS_PRESENT) || ((status_i == STATUS_FULL) && (entry_count_i == count_t'(CAPACITY))), "bad status")

endmodule

bind sorted_set_insert ssi_chk u_ssi_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .entry_count_i (out_o.entry_count),
  .position_i    (out_o.position),
  .status_i      (out_o.status)
);

@@ tb/sv/ssi_result_checker.sv @@
// result checker for the sorted set insertion block: predicts each result
// from the accepted values and compares it with what the block returns
// depends on ssi_pkg and the channel interfaces in ssi_if.sv
module ssi_result_checker import ssi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ssi_in_if    in_i,
  ssi_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    count_t  entry_count;
    count_t  position;
    status_t status;
  } result_t;

  typedef logic signed [VALUE_WIDTH-1:0] svalue_t;

  // own copy of the ordered set
  svalue_t     set_vals [CAPACITY];
  int unsigned set_size;

  result_t pending_results [$];
  result_t got;
  result_t want;
  int      shown;

  // look the value up, insert it if new and room is left, and give the result
  function automatic result_t predict_insert(input value_t raw);
    svalue_t     v;
    int unsigned n;
    int unsigned slot;
    result_t     res;
    v = svalue_t'(raw);
    n = set_size;
    slot = 0;
    // slot = number of entries strictly below the value
    while (slot < n && set_vals[slot] < v) slot++;
    if (slot < n && set_vals[slot] == v) begin
      res.status = STATUS_PRESENT;
    end else if (n >= CAPACITY) begin
      res.status = STATUS_FULL;
    end else begin
      for (int unsigned i = n; i > slot; i--) set_vals[i] = set_vals[i-1];
      set_vals[slot] = v;
      n++;
      res.status = STATUS_INSERTED;
    end
    set_size = n;
    res.entry_count = count_t'(n);
    res.position    = count_t'(slot);
    return res;
  endfunction

  // count a failure, report only the first few
  task automatic log_failure(input string what);
    fail_count_o++;
    if (shown < 10) begin
      shown++;
      $display("%s", what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size = 0;
      pending_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      shown = 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.entry_count, out_i.position, out_i.status};
        if (pending_results.size() == 0) begin
          log_failure($sformatf("unexpected result: count %0d pos %0d status %0d",
                                got.entry_count, got.position, got.status));
        end else begin
          want = pending_results.pop_front();
          if (got.entry_count !== want.entry_count || got.position !== want.position ||
              got.status !== want.status) begin
            log_failure($sformatf(
              "result mismatch: expected count %0d pos %0d status %0d, got %0d %0d %0d",
              want.entry_count, want.position, want.status,
              got.entry_count, got.position, got.status));
          end
        end
      end
      // value transfer: predict its result
      if (in_i.valid && in_i.ready) begin
        pending_results.push_back(predict_insert(in_i.new_value));
      end
      pending_o = pending_results.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top for the sorted set insertion block: clock, reset, value
// stimulus with random idling, result back-pressure and the verdict
// depends on ssi_pkg, ssi_if.sv, sorted_set_insert and ssi_result_checker
module tb_top;
  import ssi_pkg::*;

  localparam int     RANDOM_ITEMS = 1950;
  localparam int     IDLE_PCT     = 38;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     DRAIN_CYCLES = 200;
  localparam value_t VALUE_MIN    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t VALUE_MAX    = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic   clk;
  logic   rst_n;
  logic   steady;
  int     fail_count;
  int     pending;
  int     idle_cycles;
  bit     seen_vals [value_t];
  value_t sent_vals [$];

  // near-extremes, zero, sign changes, repeats and a descending run
  value_t directed_vals [17] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h8000_0001,
    32'h7FFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd40,
    32'd30, 32'd20, 32'd10, 32'h8000_0002, 32'h8000_0001,
    32'h7FFF_FFFE, 32'h0001_0000
  };

  ssi_in_if  in_if ();
  ssi_out_if out_if ();

  sorted_set_insert dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ssi_result_checker results_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result back-pressure
  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one value after a random gap and hold it until the transfer
  task automatic send_value(input value_t v);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.new_value <= v;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    if (!seen_vals.exists(v)) begin
      seen_vals[v] = 1'b1;
      sent_vals.push_back(v);
    end
  endtask

  initial begin
    value_t v;
    int     roll;
    int     new_pct;
    bit     full;
    in_if.valid     = 1'b0;
    in_if.new_value = '0;
    out_if.ready    = 1'b0;
    steady          = 1'b0;
    idle_cycles     = 0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_vals[k]) send_value(directed_vals[k]);

    for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
      // before the set is full every distinct value sent so far is stored
      full = (seen_vals.num() >= CAPACITY);
      steady <= (idx >= 900 && idx < 1250);
      // new values are rare early on so the filling spreads over many items
      new_pct = (!full && idx < 600) ? 12 : 35;
      roll = $urandom_range(0, 99);
      if (roll < new_pct) begin
        v = $urandom();
      end else if (roll < new_pct + 15) begin
        // neighbour of a known value
        v = sent_vals[$urandom_range(0, sent_vals.size() - 1)];
        v = $urandom_range(0, 1) ? v + 1'b1 : v - 1'b1;
      end else if (roll < new_pct + 22) begin
        case ($urandom_range(0, 3))
          0: begin
            v = VALUE_MIN;
          end
          1: begin
            v = VALUE_MAX;
          end
          2: begin
            v = VALUE_MIN + 1'b1;
          end
          default: begin
            v = VALUE_MAX - 1'b1;
          end
        endcase
      end else begin
        // repeat of a known value
        v = sent_vals[$urandom_range(0, sent_vals.size() - 1)];
      end
      // keep both extremes out until full, so dropped values reach both ends
      if (!full && (v == VALUE_MIN || v == VALUE_MAX)) v = v ^ value_t'(2);
      send_value(v);
    end
    in_if.valid <= 1'b0;

    // drain the outstanding results, then allow for any stray ones
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ssi_pkg.sv
rtl/ssi_if.sv
rtl/sorted_set_insert.sv
rtl/ssi_chk.sv
tb/sv/ssi_result_checker.sv
tb/sv/tb_top.sv
